// ----- design/evrp_pkg.sv -----
`default_nettype none
package evrp_pkg;

   // frame end status codes
   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_SHORT  = 3'd1;
   localparam logic [2:0] ST_HEADER = 3'd2;
   localparam logic [2:0] ST_COUNT  = 3'd3;
   localparam logic [2:0] ST_RECORD = 3'd4;
   localparam logic [2:0] ST_HIGH   = 3'd5;
   localparam logic [2:0] ST_END    = 3'd6;

   // result kinds
   localparam logic KIND_RECORD = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // input opcodes
   localparam logic OP_BYTE  = 1'b0;
   localparam logic OP_EMPTY = 1'b1;

   // byte values of the framing
   localparam logic [7:0] BYTE_ESC     = 8'hFF;
   localparam logic [7:0] BYTE_ESC_00  = 8'h01;
   localparam logic [7:0] BYTE_ESC_FF  = 8'h02;
   localparam logic [7:0] BYTE_END     = 8'h03;
   localparam logic [7:0] BYTE_HEADER  = 8'h01;
   localparam logic [7:0] COUNT_EMPTY  = 8'hFF;

   localparam int RSP_DATA_W = 32;

   // one queue entry: an optional record and an optional frame status
   typedef struct packed {
      logic               has_rec;
      logic [6:0]         rec_type;
      logic signed [15:0] rec_value;
      logic               has_stat;
      logic [2:0]         status;
      logic               hdr_mismatch;
   } entry_type;

endpackage
`default_nettype wire

// ----- design/evrp_front.sv -----
`default_nettype none
module evrp_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic               opcode,
   input  wire logic [7:0]         data_byte,
   input  wire logic               last_byte,
   output logic                    push,
   output evrp_pkg::entry_type     push_entry
);
   import evrp_pkg::*;

   typedef enum logic [3:0] {
      PH_HEADER, PH_COUNT, PH_TYPE, PH_LOW, PH_HIGH,
      PH_END0, PH_END1, PH_IGNORE, PH_SKIP
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic       esc_ff, esc_in;
   logic [7:0] vars_ff, vars_in;
   logic [6:0] type_ff, type_in;
   logic       wide_ff, wide_in;
   logic [7:0] low_ff, low_in;
   logic [2:0] err_ff, err_in;
   logic       hdr_ff, hdr_in;

   // status code for the part being read
   function automatic logic [2:0] stage_code(input phase_type ph, input logic [2:0] err);
      logic [2:0] code;
      unique case (ph)
         PH_HEADER:         code = ST_HEADER;
         PH_COUNT:          code = ST_COUNT;
         PH_TYPE, PH_LOW:   code = ST_RECORD;
         PH_HIGH:           code = ST_HIGH;
         PH_IGNORE:         code = ST_OK;
         PH_SKIP:           code = err;
         default:           code = ST_END;
      endcase
      return code;
   endfunction

   logic       first;
   logic       have;
   logic [7:0] dec;

   // per-word parse step
   always_comb begin
      phase_in   = phase_ff;
      esc_in     = esc_ff;
      vars_in    = vars_ff;
      type_in    = type_ff;
      wide_in    = wide_ff;
      low_in     = low_ff;
      err_in     = err_ff;
      hdr_in     = hdr_ff;
      push_entry = '0;
      have       = 1'b0;
      dec        = '0;
      first      = (phase_ff == PH_HEADER) && !esc_ff;

      if (accept) begin
         if (opcode == OP_EMPTY) begin
            push_entry.has_stat = 1'b1;
            push_entry.status   = ST_OK;
         end else begin
            unique case (phase_ff)
               PH_HEADER, PH_COUNT, PH_TYPE, PH_LOW, PH_HIGH: begin
                  // escape decode
                  if (esc_ff) begin
                     esc_in = 1'b0;
                     if (data_byte == BYTE_ESC_00) begin
                        dec  = 8'h00;
                        have = 1'b1;
                     end else if (data_byte == BYTE_ESC_FF) begin
                        dec  = 8'hFF;
                        have = 1'b1;
                     end else begin
                        err_in   = stage_code(phase_ff, err_ff);
                        phase_in = PH_SKIP;
                     end
                  end else if (data_byte == BYTE_ESC) begin
                     esc_in = 1'b1;
                  end else begin
                     dec  = data_byte;
                     have = 1'b1;
                  end
                  // field decode
                  if (have) begin
                     unique case (phase_ff)
                        PH_HEADER: begin
                           hdr_in   = (dec != BYTE_HEADER);
                           phase_in = PH_COUNT;
                        end
                        PH_COUNT: begin
                           if (dec == COUNT_EMPTY) begin
                              phase_in = PH_IGNORE;
                           end else begin
                              vars_in  = dec;
                              phase_in = (dec == 8'h00) ? PH_END0 : PH_TYPE;
                           end
                        end
                        PH_TYPE: begin
                           type_in  = dec[6:0];
                           wide_in  = dec[7];
                           phase_in = PH_LOW;
                        end
                        PH_LOW: begin
                           low_in = dec;
                           if (wide_ff) begin
                              phase_in = PH_HIGH;
                           end else begin
                              push_entry.has_rec   = 1'b1;
                              push_entry.rec_type  = type_ff;
                              push_entry.rec_value = {8'h00, dec};
                              vars_in  = vars_ff - 8'd1;
                              phase_in = (vars_in == 8'h00) ? PH_END0 : PH_TYPE;
                           end
                        end
                        default: begin
                           push_entry.has_rec   = 1'b1;
                           push_entry.rec_type  = type_ff;
                           push_entry.rec_value = {dec, low_ff};
                           vars_in  = vars_ff - 8'd1;
                           phase_in = (vars_in == 8'h00) ? PH_END0 : PH_TYPE;
                        end
                     endcase
                  end
               end
               PH_END0: begin
                  if (data_byte == BYTE_ESC) begin
                     phase_in = PH_END1;
                  end else begin
                     err_in   = ST_END;
                     phase_in = PH_SKIP;
                  end
               end
               PH_END1: begin
                  if (data_byte == BYTE_END && last_byte) begin
                     phase_in = PH_IGNORE;
                  end else begin
                     err_in   = ST_END;
                     phase_in = PH_SKIP;
                  end
               end
               default: begin
               end
            endcase

            // frame end status
            if (last_byte) begin
               push_entry.has_stat     = 1'b1;
               push_entry.status       = first ? ST_SHORT : stage_code(phase_in, err_in);
               push_entry.hdr_mismatch = first ? 1'b0 : hdr_in;
            end
         end

         // frame state returns to idle after any frame end
         if (opcode == OP_EMPTY || last_byte) begin
            phase_in = PH_HEADER;
            esc_in   = 1'b0;
            vars_in  = '0;
            type_in  = '0;
            wide_in  = 1'b0;
            low_in   = '0;
            err_in   = ST_OK;
            hdr_in   = 1'b0;
         end
      end
      push = accept && (push_entry.has_rec || push_entry.has_stat);
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         esc_ff   <= 1'b0;
         vars_ff  <= '0;
         type_ff  <= '0;
         wide_ff  <= 1'b0;
         low_ff   <= '0;
         err_ff   <= ST_OK;
         hdr_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         esc_ff   <= esc_in;
         vars_ff  <= vars_in;
         type_ff  <= type_in;
         wide_ff  <= wide_in;
         low_ff   <= low_in;
         err_ff   <= err_in;
         hdr_ff   <= hdr_in;
      end
   end

   a_skip_has_code: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SKIP |-> err_ff != ST_OK)
      else $error("skip phase without an error code");

   a_pending_escape_only_in_fields: assert property (@(posedge clock) disable iff (reset)
      esc_ff |-> phase_ff == PH_HEADER || phase_ff == PH_COUNT || phase_ff == PH_TYPE
                 || phase_ff == PH_LOW || phase_ff == PH_HIGH)
      else $error("escape pending outside field parsing");

   a_word_ends_frame: assert property (@(posedge clock) disable iff (reset)
      accept && (opcode == OP_EMPTY || last_byte) |-> push && push_entry.has_stat)
      else $error("frame end gave no status");

endmodule
`default_nettype wire

// ----- design/evrp_queue.sv -----
`default_nettype none
module evrp_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire evrp_pkg::entry_type push_entry,
   input  wire logic                pop,
   output logic                     full,
   output logic                     head_valid,
   output evrp_pkg::entry_type      head_entry
);
   import evrp_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type       slot_ff [DEPTH];
   logic [AW-1:0]   wr_ff, wr_in;
   logic [AW-1:0]   rd_ff, rd_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // pointer and fill count update
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into a full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count beyond depth");

   a_entry_not_empty: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> head_entry.has_rec || head_entry.has_stat)
      else $error("queued entry carries no result");

endmodule
`default_nettype wire

// ----- design/evrp_back.sv -----
`default_nettype none
module evrp_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          head_valid,
   input  wire evrp_pkg::entry_type           head_entry,
   output logic                               pop,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [evrp_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tuser,
   output logic                               rsp_tlast
);
   import evrp_pkg::*;

   entry_type ent_ff, ent_in;
   logic      vld_ff, vld_in;
   logic      part_ff, part_in;
   logic      is_rec, take, done, load;

   // current result of the held entry
   assign is_rec     = !part_ff && ent_ff.has_rec;
   assign rsp_tvalid = vld_ff;
   assign rsp_tuser  = is_rec ? KIND_RECORD : KIND_STATUS;
   assign rsp_tlast  = is_rec ? !ent_ff.has_stat : 1'b1;
   assign rsp_tdata  = is_rec
      ? {5'd0, 1'b0, ST_OK, ent_ff.rec_value, ent_ff.rec_type}
      : {5'd0, ent_ff.hdr_mismatch, ent_ff.status, 16'd0, 7'd0};

   assign take = vld_ff && rsp_tready;
   assign done = take && rsp_tlast;
   assign load = !vld_ff || done;
   assign pop  = load && head_valid;

   // entry hand-off and result sequencing
   always_comb begin
      ent_in  = ent_ff;
      vld_in  = vld_ff;
      part_in = part_ff;
      if (load) begin
         vld_in  = head_valid;
         ent_in  = head_entry;
         part_in = 1'b0;
      end else if (take) begin
         part_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= 1'b0;
         part_ff <= 1'b0;
      end else begin
         vld_ff  <= vld_in;
         part_ff <= part_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   a_status_fields_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_STATUS |-> rsp_tdata[22:0] == '0 && rsp_tlast)
      else $error("status word carries record fields");

   a_record_fields_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_RECORD |-> rsp_tdata[26:23] == '0)
      else $error("record word carries status fields");

   a_second_part_is_status: assert property (@(posedge clock) disable iff (reset)
      take && !rsp_tlast |=> vld_ff && rsp_tuser == KIND_STATUS)
      else $error("record not followed by its status");

endmodule
`default_nettype wire

// ----- design/escaped_variable_record_parser.sv -----
`default_nettype none
// Escaped variable record parser. Takes one raw frame byte per word on req_
// (tuser = 1 marks an empty frame, tlast the frame's final byte) and returns
// decoded records and one end-of-frame status on rsp_. The front parser
// handles a byte in the cycle it is accepted, so the input runs at one word
// per cycle while the queue is not full; a word that both completes a record
// and ends the frame yields two result words, which the output stage sends
// one after the other, record first. A queue of QUEUE_DEPTH entries between
// parser and output stage absorbs such bursts and output stalls. Records of
// a frame whose status is non-zero are to be discarded by the consumer.
module escaped_variable_record_parser #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [7:0]                    req_tdata,  // data_byte
   input  wire logic                          req_tuser,  // opcode
   input  wire logic                          req_tlast,  // last_byte
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // var_type[6:0], var_value[22:7], status[25:23], header_mismatch[26], zero
   output logic [evrp_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tuser,  // kind
   output logic                               rsp_tlast   // run_last
);
   import evrp_pkg::*;

   logic      accept, push, pop, full, head_valid;
   entry_type push_entry, head_entry;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   // byte parser
   evrp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .opcode     (req_tuser),
      .data_byte  (req_tdata),
      .last_byte  (req_tlast),
      .push       (push),
      .push_entry (push_entry)
   );

   // result queue
   evrp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // output sequencer
   evrp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import evrp_pkg::*;

   localparam int WORD_TARGET  = 1700;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 300;

   // predictor and store of expected result words
   class record_scoreboard;
      typedef enum logic [3:0] {
         P_HEADER, P_COUNT, P_TYPE, P_LOW, P_HIGH, P_END0, P_END1, P_IGNORE, P_SKIP
      } parse_phase_type;

      typedef struct packed {
         logic               kind;
         logic [6:0]         vtype;
         logic signed [15:0] value;
         logic [2:0]         status;
         logic               hdr_bad;
         logic               run_last;
      } result_type;

      parse_phase_type phase;
      bit           esc_pending;
      logic [7:0]   vars_left;
      logic [6:0]   type_hold;
      bit           wide_flag;
      logic [7:0]   low_hold;
      logic [2:0]   err_code;
      bit           hdr_flag;

      result_type pending_q[$];
      int      errors;
      int      records_seen;
      int      statuses_seen;
      int      failed_frames;

      function new();
         clear_frame();
      endfunction

      function void clear_frame();
         phase       = P_HEADER;
         esc_pending = 0;
         vars_left   = '0;
         type_hold   = '0;
         wide_flag   = 0;
         low_hold    = '0;
         err_code    = '0;
         hdr_flag    = 0;
      endfunction

      // status code naming the part of the frame being read
      function logic [2:0] stage_status(parse_phase_type ph);
         case (ph)
            P_HEADER:      return ST_HEADER;
            P_COUNT:       return ST_COUNT;
            P_TYPE, P_LOW: return ST_RECORD;
            P_HIGH:        return ST_HIGH;
            P_IGNORE:      return ST_OK;
            P_SKIP:        return err_code;
            default:       return ST_END;
         endcase
      endfunction

      function void abort(logic [2:0] code);
         err_code    = code;
         esc_pending = 0;
         phase       = P_SKIP;
      endfunction

      function void record_done();
         vars_left = vars_left - 8'd1;
         phase     = (vars_left == 8'd0) ? P_END0 : P_TYPE;
      endfunction

      function result_type record_result(logic [15:0] value);
         result_type r;
         r          = '0;
         r.kind     = KIND_RECORD;
         r.vtype    = type_hold;
         r.value    = value;
         return r;
      endfunction

      function result_type status_result(logic [2:0] code, logic hdr_bad);
         result_type r;
         r         = '0;
         r.kind    = KIND_STATUS;
         r.status  = code;
         r.hdr_bad = hdr_bad;
         return r;
      endfunction

      // work out the results of one accepted input word
      function void note_word(logic op, logic [7:0] b, logic last);
         result_type out_q[$];
         result_type r;
         logic [7:0] d;
         bit         have;
         bit         first;
         first = (phase == P_HEADER) && !esc_pending;
         have  = 0;
         d     = '0;
         if (op == OP_EMPTY) begin
            clear_frame();
            r = status_result(ST_OK, 1'b0);
            r.run_last = 1'b1;
            pending_q.push_back(r);
            return;
         end
         if (phase <= P_HIGH) begin
            // escape decoding
            if (esc_pending) begin
               esc_pending = 0;
               if (b == BYTE_ESC_00) begin
                  d    = 8'h00;
                  have = 1;
               end else if (b == BYTE_ESC_FF) begin
                  d    = 8'hFF;
                  have = 1;
               end else begin
                  abort(stage_status(phase));
               end
            end else if (b == BYTE_ESC) begin
               esc_pending = 1;
            end else begin
               d    = b;
               have = 1;
            end
            // field parsing on a decoded byte
            if (have) begin
               case (phase)
                  P_HEADER: begin
                     hdr_flag = (d != BYTE_HEADER);
                     phase    = P_COUNT;
                  end
                  P_COUNT: begin
                     if (d == COUNT_EMPTY) begin
                        phase = P_IGNORE;
                     end else begin
                        vars_left = d;
                        phase     = (d == 8'd0) ? P_END0 : P_TYPE;
                     end
                  end
                  P_TYPE: begin
                     type_hold = d[6:0];
                     wide_flag = d[7];
                     phase     = P_LOW;
                  end
                  P_LOW: begin
                     low_hold = d;
                     if (wide_flag) begin
                        phase = P_HIGH;
                     end else begin
                        out_q.push_back(record_result({8'h00, low_hold}));
                        record_done();
                     end
                  end
                  default: begin
                     out_q.push_back(record_result({d, low_hold}));
                     record_done();
                  end
               endcase
            end
         end else if (phase == P_END0) begin
            if (b == BYTE_ESC) phase = P_END1;
            else abort(ST_END);
         end else if (phase == P_END1) begin
            if (b == BYTE_END && last) phase = P_IGNORE;
            else abort(ST_END);
         end
         // frame end status
         if (last) begin
            out_q.push_back(status_result(first ? ST_SHORT : stage_status(phase),
                                          first ? 1'b0 : hdr_flag));
            clear_frame();
         end
         if (out_q.size() > 0) begin
            r = out_q.pop_back();
            r.run_last = 1'b1;
            out_q.push_back(r);
         end
         foreach (out_q[i]) pending_q.push_back(out_q[i]);
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         $display("%0t mismatch: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
      endtask

      // compare one accepted result word with the oldest expectation
      task check_word(logic [31:0] data, logic user, logic last);
         result_type want;
         if (pending_q.size() == 0) begin
            report_mismatch("result word with nothing expected", data, '0);
            return;
         end
         want = pending_q.pop_front();
         if (want.kind == KIND_STATUS) begin
            statuses_seen++;
            if (want.status != ST_OK) failed_frames++;
         end else begin
            records_seen++;
         end
         if (user !== want.kind)
            report_mismatch("kind", 32'(user), 32'(want.kind));
         if (data[6:0] !== want.vtype)
            report_mismatch("var_type", 32'(data[6:0]), 32'(want.vtype));
         if (data[22:7] !== want.value)
            report_mismatch("var_value", 32'(data[22:7]), 32'(unsigned'(want.value)));
         if (data[25:23] !== want.status)
            report_mismatch("status", 32'(data[25:23]), 32'(want.status));
         if (data[26] !== want.hdr_bad)
            report_mismatch("header_mismatch", 32'(data[26]), 32'(want.hdr_bad));
         if (data[31:27] !== 5'd0)
            report_mismatch("padding", 32'(data[31:27]), '0);
         if (last !== want.run_last)
            report_mismatch("run_last", 32'(last), 32'(want.run_last));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // data_byte
   logic        req_tuser = 1'b0; // opcode
   logic        req_tlast = 1'b0; // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // var_type[6:0], var_value[22:7], status[25:23], header_mismatch[26], zero
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;        // kind
   logic        rsp_tlast;        // run_last

   record_scoreboard sb = new();

   int idle_pct   = 0;
   int stall_pct  = 0;
   int hold_left  = 0;
   int words_sent = 0;
   int sim_cycles = 0;

   escaped_variable_record_parser DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // clock, 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      sim_cycles <= sim_cycles + 1;
      if (sim_cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", sim_cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver: random stalls, or a long hold-off when one is pending
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // offer one word, called at a falling edge, returns at a falling edge
   task automatic send_word(input logic op, input logic [7:0] data, input logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = data;
      req_tlast  = last;
      do @(posedge clock); while (!req_tready);
      sb.note_word(op, data, last);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_bytes(input logic [7:0] raw[$], input bit close);
      foreach (raw[k]) send_word(OP_BYTE, raw[k], close && (k == raw.size() - 1));
   endtask

   // escape one decoded byte; zero goes either plain or escaped
   function automatic void push_escaped(ref logic [7:0] raw[$], input logic [7:0] d);
      if (d == 8'hFF) begin
         raw.push_back(BYTE_ESC);
         raw.push_back(BYTE_ESC_FF);
      end else if (d == 8'h00 && $urandom_range(1) == 1) begin
         raw.push_back(BYTE_ESC);
         raw.push_back(BYTE_ESC_00);
      end else begin
         raw.push_back(d);
      end
   endfunction

   // one random frame: mostly well formed, the rest broken or noise
   task automatic random_frame();
      logic [7:0] dec[$];
      logic [7:0] raw[$];
      logic [7:0] prefix[$];
      logic [7:0] t;
      logic [7:0] bad;
      int         flavour;
      int         n_rec;
      int         bad_at;
      int         cut;
      flavour = $urandom_range(99);
      bad_at  = -1;
      if (flavour < 8) begin
         // noise
         repeat ($urandom_range(1, 6)) raw.push_back(8'($urandom_range(255)));
         send_bytes(raw, 1);
         return;
      end
      if (flavour < 11) begin
         send_word(OP_EMPTY, 8'($urandom_range(255)), 1'($urandom_range(1)));
         return;
      end
      dec.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : BYTE_HEADER);
      if (flavour >= 95) begin
         // empty set, trailing bytes ignored
         push_escaped(raw, dec[0]);
         push_escaped(raw, COUNT_EMPTY);
         repeat ($urandom_range(3)) raw.push_back(8'($urandom_range(255)));
         send_bytes(raw, 1);
         return;
      end
      n_rec = ($urandom_range(15) == 0) ? $urandom_range(5, 24) : $urandom_range(0, 4);
      dec.push_back(8'(n_rec));
      repeat (n_rec) begin
         t = 8'($urandom_range(255));
         dec.push_back(t);
         dec.push_back(8'($urandom_range(255)));
         if (t[7]) dec.push_back(8'($urandom_range(255)));
      end
      if (flavour >= 61 && flavour <= 70) bad_at = $urandom_range(0, dec.size() - 1);
      foreach (dec[k]) begin
         if (k == bad_at) begin
            do bad = 8'($urandom_range(255));
            while (bad == BYTE_ESC_00 || bad == BYTE_ESC_FF);
            raw.push_back(BYTE_ESC);
            raw.push_back(bad);
         end else begin
            push_escaped(raw, dec[k]);
         end
      end
      // end marker, possibly damaged
      if (flavour >= 71 && flavour <= 78) begin
         case ($urandom_range(2))
            0: begin
               raw.push_back(8'($urandom_range(255)));
               raw.push_back(8'($urandom_range(255)));
            end
            1: begin
               raw.push_back(BYTE_ESC);
               raw.push_back(BYTE_END);
               repeat ($urandom_range(1, 3)) raw.push_back(8'($urandom_range(255)));
            end
            default: raw.push_back(BYTE_ESC);
         endcase
      end else begin
         raw.push_back(BYTE_ESC);
         raw.push_back(BYTE_END);
      end
      if (flavour >= 79 && flavour <= 88) begin
         // frame cut short
         cut = $urandom_range(1, raw.size());
         prefix = raw[0:cut-1];
         send_bytes(prefix, 1);
      end else if (flavour >= 89 && flavour <= 94) begin
         // empty frame arriving inside a partial one
         cut = $urandom_range(1, raw.size() - 1);
         prefix = raw[0:cut-1];
         send_bytes(prefix, 0);
         send_word(OP_EMPTY, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
         send_bytes(raw, 1);
      end
   endtask

   initial begin
      logic [7:0] raw[$];
      int         phase_end;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed frames
      idle_pct  = 30;
      stall_pct = 30;
      send_word(OP_EMPTY, 8'hFF, 1'b1);
      raw = {BYTE_ESC};
      send_bytes(raw, 1);
      raw = {BYTE_HEADER, 8'h00, BYTE_ESC, BYTE_END};
      send_bytes(raw, 1);
      // narrow record with 0xFF low, wide record with value -32768
      raw = {BYTE_HEADER, 8'h02, 8'h7F, BYTE_ESC, BYTE_ESC_FF,
             8'h85, BYTE_ESC, BYTE_ESC_00, 8'h80, BYTE_ESC, BYTE_END};
      send_bytes(raw, 1);
      raw = {BYTE_HEADER, BYTE_ESC, BYTE_ESC_FF, 8'h5A};
      send_bytes(raw, 1);
      raw = {8'h07};
      send_bytes(raw, 0);
      send_word(OP_EMPTY, 8'h00, 1'b0);
      raw = {8'h00, BYTE_ESC, BYTE_END};
      send_bytes(raw, 1);

      // random frames in four idling phases
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 73; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 73; end
            default: begin idle_pct = 14; stall_pct = 14; end
         endcase
         if (p == 0) begin
            // long receiver hold-off while words keep coming
            req_tvalid = 1'b0;
            @(posedge clock);
            hold_left = HOLD_CYCLES;
            @(negedge clock);
         end
         phase_end = words_sent + WORD_TARGET / 4;
         while (words_sent < phase_end) random_frame();
      end

      req_tvalid = 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d words; checked %0d records and %0d frame statuses",
               words_sent, sb.records_seen, sb.statuses_seen);
      $display("%0d frames ended with a non-zero status", sb.failed_frames);
      if (sb.errors == 0 && sb.pending_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ----- escaped_variable_record_parser.f -----
design/evrp_pkg.sv
design/evrp_front.sv
design/evrp_queue.sv
design/evrp_back.sv
design/escaped_variable_record_parser.sv
dv/tb.sv
